// ----- rtl/lbp_texture_histogram_assert.svh -----
// Assertion helpers for the checker file of the texture histogram block.
`ifndef LBP_TEXTURE_HISTOGRAM_ASSERT_SVH
`define LBP_TEXTURE_HISTOGRAM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBP_TH_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBP_TH_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- rtl/lbp_th_pkg.sv -----
`timescale 1ns / 1ps

package lbp_th_pkg;

   localparam int PIXEL_W            = 8;
   localparam int CODE_W             = 8;
   localparam int COORD_W            = 10;
   localparam int HIST_BINS          = 16;
   localparam int BIN_W              = 4;
   localparam int COUNT_W            = 21;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 11;
   localparam int REQ_DATA_W         = 8;
   localparam int QUEUE_DEPTH        = 4;
   localparam int QPTR_W             = 2;
   localparam int QCOUNT_W           = 3;
   localparam int MIN_SIZE           = 3;
   localparam int FRAME_WIDTH_RESET  = 1024;
   localparam int FRAME_HEIGHT_RESET = 1024;

   localparam logic [COUNT_W-1:0]     COUNT_MAX        = {COUNT_W{1'b1}};
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [BIN_W-1:0]   bin_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam bin_type BIN_LAST = bin_type'(HIST_BINS - 1);

   // One classified pixel on its way from the window logic to the histogram.
   typedef struct packed {
      pixel_type pixel;
      logic      border;
      logic      has_code;
      code_type  code;
      coord_type center_row;
      coord_type center_col;
      logic      frame_end;
   } token_type;

   typedef struct packed {
      logic [2:0] pad;
      count_type  bin_count;
      bin_type    bin;
      coord_type  center_col;
      coord_type  center_row;
      code_type   code;
   } rsp_data_type;

   localparam int RSP_DATA_W = $bits(rsp_data_type);

   function automatic int clamp_last(input int size, input int hi);
      int v;
      v = size;
      if (v < MIN_SIZE) begin
         v = MIN_SIZE;
      end else if (v > hi) begin
         v = hi;
      end
      return v - 1;
   endfunction

   function automatic bin_type value_bin(input pixel_type v);
      return v[PIXEL_W-1 -: BIN_W];
   endfunction

endpackage

// ----- rtl/lbp_texture_histogram.sv -----
`timescale 1ns / 1ps

// Computes 3x3 local binary pattern codes for a grayscale pixel stream in raster order
// and a 16-bin histogram of the texture image, with border pixels counted by gray value.
// One pixel is taken per clock while the result side keeps up; a code word leaves three
// pipeline stages later, once the pixel completing its window has arrived. After the last
// pixel of a frame the block sends 16 histogram words, one per clock while the result side
// accepts them, then clears the histogram; while they are sent, pixels are absorbed only by
// the window stage and the four-entry queue in front of the histogram, after which the
// input stalls until the last histogram word is loaded.
// Two line stores of MAX_WIDTH bytes each hold the previous rows. Writing either size
// register restarts the frame and clears the histogram; sizes are clamped to the range
// from 3 to MAX_WIDTH or MAX_HEIGHT.
module lbp_texture_histogram #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pixel
   input  logic [lbp_th_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // code, center_row, center_col, bin, bin_count, zero fill
   output logic [lbp_th_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // kind
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lbp_th_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lbp_th_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   localparam logic [CW-1:0] LAST_COL_RESET =
      CW'(lbp_th_pkg::clamp_last(lbp_th_pkg::FRAME_WIDTH_RESET, MAX_WIDTH));
   localparam logic [RW-1:0] LAST_ROW_RESET =
      RW'(lbp_th_pkg::clamp_last(lbp_th_pkg::FRAME_HEIGHT_RESET, MAX_HEIGHT));

   logic [CW-1:0] last_col_ff, last_col_in;
   logic [RW-1:0] last_row_ff, last_row_in;
   logic          csr_write, restart;

   logic                  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   lbp_th_pkg::token_type q_push_entry, q_pop_entry;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      restart     = 1'b0;
      if (csr_write) begin
         case (csr_index)
            lbp_th_pkg::REG_FRAME_WIDTH: begin
               last_col_in = CW'(lbp_th_pkg::clamp_last(int'(csr_data), MAX_WIDTH));
               restart     = 1'b1;
            end
            lbp_th_pkg::REG_FRAME_HEIGHT: begin
               last_row_in = RW'(lbp_th_pkg::clamp_last(int'(csr_data), MAX_HEIGHT));
               restart     = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= LAST_COL_RESET;
         last_row_ff <= LAST_ROW_RESET;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
      end
   end

   lbp_th_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .last_col  (last_col_ff),
      .last_row  (last_row_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pixel  (req_tdata[lbp_th_pkg::PIXEL_W-1:0]),
      .out_valid (q_push_valid),
      .out_ready (q_push_ready),
      .out_entry (q_push_entry)
   );

   lbp_th_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_entry (q_push_entry),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_entry  (q_pop_entry)
   );

   lbp_th_back u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .in_valid   (q_pop_valid),
      .in_ready   (q_pop_ready),
      .in_entry   (q_pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/lbp_th_ram.sv -----
`timescale 1ns / 1ps

module lbp_th_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lbp_th_front.sv -----
`timescale 1ns / 1ps

module lbp_th_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic [$clog2(MAX_WIDTH)-1:0]  last_col,
   input  logic [$clog2(MAX_HEIGHT)-1:0] last_row,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  lbp_th_pkg::pixel_type         in_pixel,
   output logic                          out_valid,
   input  logic                          out_ready,
   output lbp_th_pkg::token_type         out_entry
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          s1_valid_ff, s1_valid_in;

   lbp_th_pkg::pixel_type s1_px_ff;
   logic [CW-1:0]         s1_col_ff;
   logic                  s1_border_ff;
   logic                  s1_has_code_ff;
   logic                  s1_end_ff;
   lbp_th_pkg::coord_type s1_crow_ff;
   lbp_th_pkg::coord_type s1_ccol_ff;

   logic [8:0][lbp_th_pkg::PIXEL_W-1:0] win_ff, win_in;
   lbp_th_pkg::pixel_type up_rd, mid_rd, ctr;
   lbp_th_pkg::code_type  code;

   logic accept, push, at_last_col, at_last_row;

   assign in_ready    = !s1_valid_ff || out_ready;
   assign accept      = in_valid && in_ready;
   assign push        = s1_valid_ff && out_ready;
   assign out_valid   = s1_valid_ff;
   assign at_last_col = (col_ff == last_col);
   assign at_last_row = (row_ff == last_row);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (restart) begin
         s1_valid_in = 1'b0;
      end else if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= in_pixel;
         s1_col_ff      <= col_ff;
         s1_border_ff   <= (row_ff == '0) || at_last_row || (col_ff == '0) || at_last_col;
         s1_has_code_ff <= (row_ff >= RW'(2)) && (col_ff >= CW'(2));
         s1_end_ff      <= at_last_row && at_last_col;
         s1_crow_ff     <= lbp_th_pkg::coord_type'(row_ff - RW'(1));
         s1_ccol_ff     <= lbp_th_pkg::coord_type'(col_ff - CW'(1));
      end
   end

   lbp_th_ram #(
      .WIDTH (lbp_th_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up_rd)
   );

   lbp_th_ram #(
      .WIDTH (lbp_th_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_middle (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (mid_rd)
   );

   // The window keeps three rows of three columns; the newest column is on the right.
   always_comb begin
      win_in = win_ff;
      if (push) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = up_rd;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = mid_rd;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_comb begin
      ctr     = win_in[4];
      code[0] = win_in[0] > ctr;
      code[1] = win_in[1] > ctr;
      code[2] = win_in[2] > ctr;
      code[3] = win_in[3] > ctr;
      code[4] = win_in[5] > ctr;
      code[5] = win_in[6] > ctr;
      code[6] = win_in[7] > ctr;
      code[7] = win_in[8] > ctr;
   end

   always_comb begin
      out_entry.pixel      = s1_px_ff;
      out_entry.border     = s1_border_ff;
      out_entry.has_code   = s1_has_code_ff;
      out_entry.code       = code;
      out_entry.center_row = s1_crow_ff;
      out_entry.center_col = s1_ccol_ff;
      out_entry.frame_end  = s1_end_ff;
   end

endmodule

// ----- rtl/lbp_th_queue.sv -----
`timescale 1ns / 1ps

module lbp_th_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  lbp_th_pkg::token_type push_entry,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output lbp_th_pkg::token_type pop_entry
);

   lbp_th_pkg::token_type mem_ff [lbp_th_pkg::QUEUE_DEPTH];

   logic [lbp_th_pkg::QPTR_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [lbp_th_pkg::QCOUNT_W-1:0] count_ff, count_in;
   logic                            push, pop;

   assign push_ready = (count_ff != lbp_th_pkg::QCOUNT_W'(lbp_th_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (restart) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else begin
         if (push) begin
            tail_in = tail_ff + 1'b1;
         end
         if (pop) begin
            head_in = head_ff + 1'b1;
         end
         if (push && !pop) begin
            count_in = count_ff + 1'b1;
         end else if (pop && !push) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/lbp_th_back.sv -----
`timescale 1ns / 1ps

module lbp_th_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     restart,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  lbp_th_pkg::token_type    in_entry,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output lbp_th_pkg::rsp_data_type rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);

   localparam logic ST_RUN  = 1'b0;
   localparam logic ST_DUMP = 1'b1;
   localparam int   SUM_W   = lbp_th_pkg::COUNT_W + 1;

   logic                state_ff, state_in;
   lbp_th_pkg::bin_type bin_ff, bin_in;

   lbp_th_pkg::count_type hist_ff [lbp_th_pkg::HIST_BINS];
   lbp_th_pkg::count_type hist_in [lbp_th_pkg::HIST_BINS];

   logic                     rsp_valid_ff, rsp_valid_in;
   lbp_th_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_load;

   lbp_th_pkg::bin_type px_bin, code_bin;
   logic                out_free, pop, dump_load, dump_done, hit_a, hit_b;
   logic [1:0]          inc;
   logic [SUM_W-1:0]    sum;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign in_ready  = (state_ff == ST_RUN) && (!in_entry.has_code || out_free);
   assign pop       = in_valid && in_ready;
   assign dump_load = (state_ff == ST_DUMP) && out_free;
   assign dump_done = dump_load && (bin_ff == lbp_th_pkg::BIN_LAST);
   assign px_bin    = lbp_th_pkg::value_bin(in_entry.pixel);
   assign code_bin  = lbp_th_pkg::value_bin(in_entry.code);

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      if (restart) begin
         state_in = ST_RUN;
         bin_in   = '0;
      end else begin
         case (state_ff)
            ST_RUN: begin
               if (pop && in_entry.frame_end) begin
                  state_in = ST_DUMP;
                  bin_in   = '0;
               end
            end
            ST_DUMP: begin
               if (dump_load) begin
                  bin_in = bin_ff + 1'b1;
               end
               if (dump_done) begin
                  state_in = ST_RUN;
               end
            end
            default: begin
               state_in = ST_RUN;
            end
         endcase
      end
   end

   // Each bin may take one border value and one code from the same queue entry.
   always_comb begin
      hit_a = 1'b0;
      hit_b = 1'b0;
      inc   = '0;
      sum   = '0;
      for (int i = 0; i < lbp_th_pkg::HIST_BINS; i++) begin
         hit_a = pop && in_entry.border && (px_bin == lbp_th_pkg::bin_type'(i));
         hit_b = pop && in_entry.has_code && (code_bin == lbp_th_pkg::bin_type'(i));
         inc   = {1'b0, hit_a} + {1'b0, hit_b};
         sum   = {1'b0, hist_ff[i]} + SUM_W'(inc);
         if (restart || dump_done) begin
            hist_in[i] = '0;
         end else if (sum > {1'b0, lbp_th_pkg::COUNT_MAX}) begin
            hist_in[i] = lbp_th_pkg::COUNT_MAX;
         end else begin
            hist_in[i] = sum[lbp_th_pkg::COUNT_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = '0;
      rsp_kind_in  = 1'b0;
      rsp_last_in  = 1'b0;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (pop && in_entry.has_code) begin
         rsp_valid_in           = 1'b1;
         rsp_load               = 1'b1;
         rsp_data_in.code       = in_entry.code;
         rsp_data_in.center_row = in_entry.center_row;
         rsp_data_in.center_col = in_entry.center_col;
      end else if (dump_load) begin
         rsp_valid_in          = 1'b1;
         rsp_load              = 1'b1;
         rsp_kind_in           = 1'b1;
         rsp_data_in.bin       = bin_ff;
         rsp_data_in.bin_count = hist_ff[bin_ff];
         rsp_last_in           = (bin_ff == lbp_th_pkg::BIN_LAST);
      end
      if (restart) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         bin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < lbp_th_pkg::HIST_BINS; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bin_ff       <= bin_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < lbp_th_pkg::HIST_BINS; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/lbp_th_checker.sv -----
`timescale 1ns / 1ps
`include "lbp_texture_histogram_assert.svh"

module lbp_th_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [lbp_th_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);

   `LBP_TH_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result word changed while stalled")

   `LBP_TH_ASSERT_NOW(a_last_is_final_bin, rsp_tvalid && rsp_tlast, rsp_tuser && (rsp_tdata[31:28] == 4'hF), "last word is not the final histogram bin")

   `LBP_TH_ASSERT_NOW(a_code_word_clean, rsp_tvalid && !rsp_tuser, !rsp_tlast && (rsp_tdata[52:28] == '0), "code word carries histogram fields")

   `LBP_TH_ASSERT_NEXT(a_bins_in_order, rsp_tvalid && rsp_tready && rsp_tuser && !rsp_tlast, rsp_tvalid && rsp_tuser && (rsp_tdata[31:28] == $past(rsp_tdata[31:28]) + 4'd1), "histogram bins not sent back to back in order")

endmodule

bind lbp_texture_histogram lbp_th_checker u_lbp_th_checker (.*);
